// ===== rtl/core/rine_pkg.sv =====
// Shared types, constants and the per-term schedule for the robust ICP
// normal-equation accumulator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rine_pkg;

	localparam int NUM_SUMS = 27;
	localparam logic [4:0] LAST_ENTRY = 5'd26;
	localparam logic [4:0] LAST_TERM = 5'd26;
	localparam logic [32:0] W_ONE = 33'h1_0000_0000;

	typedef struct packed {
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_z;
		logic signed [31:0] map_x;
		logic signed [31:0] map_y;
		logic signed [31:0] map_z;
		logic               final_pair;
	} in_item_t;

	typedef struct packed {
		logic [4:0]         entry_index;
		logic signed [63:0] entry_value;
		logic               run_last;
	} out_item_t;

	// Operand sources of one product term
	typedef enum logic [2:0] {
		OP_ONE = 3'd0,
		OP_PX  = 3'd1,
		OP_PY  = 3'd2,
		OP_PZ  = 3'd3,
		OP_RX  = 3'd4,
		OP_RY  = 3'd5,
		OP_RZ  = 3'd6
	} opsel_t;

	// Fraction bits to drop after weighting
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_16 = 2'd1,
		SH_32 = 2'd2
	} shift_t;

	typedef struct packed {
		logic [4:0] idx;
		opsel_t     opa;
		opsel_t     opb;
		logic       neg;
		shift_t     sh;
	} term_t;

	// Term schedule: target sum, operands, extra negation, shift
	function automatic term_t term_of(input logic [4:0] step);
		term_t t;
		case (step)
			5'd0:  t = '{5'd0,  OP_ONE, OP_ONE, 1'b0, SH_0};
			5'd1:  t = '{5'd4,  OP_PZ,  OP_ONE, 1'b0, SH_16};
			5'd2:  t = '{5'd5,  OP_PY,  OP_ONE, 1'b1, SH_16};
			5'd3:  t = '{5'd6,  OP_ONE, OP_ONE, 1'b0, SH_0};
			5'd4:  t = '{5'd8,  OP_PZ,  OP_ONE, 1'b1, SH_16};
			5'd5:  t = '{5'd10, OP_PX,  OP_ONE, 1'b0, SH_16};
			5'd6:  t = '{5'd11, OP_ONE, OP_ONE, 1'b0, SH_0};
			5'd7:  t = '{5'd12, OP_PY,  OP_ONE, 1'b0, SH_16};
			5'd8:  t = '{5'd13, OP_PX,  OP_ONE, 1'b1, SH_16};
			5'd9:  t = '{5'd15, OP_PY,  OP_PY,  1'b0, SH_32};
			5'd10: t = '{5'd15, OP_PZ,  OP_PZ,  1'b0, SH_32};
			5'd11: t = '{5'd16, OP_PX,  OP_PY,  1'b1, SH_32};
			5'd12: t = '{5'd17, OP_PX,  OP_PZ,  1'b1, SH_32};
			5'd13: t = '{5'd18, OP_PX,  OP_PX,  1'b0, SH_32};
			5'd14: t = '{5'd18, OP_PZ,  OP_PZ,  1'b0, SH_32};
			5'd15: t = '{5'd19, OP_PY,  OP_PZ,  1'b1, SH_32};
			5'd16: t = '{5'd20, OP_PX,  OP_PX,  1'b0, SH_32};
			5'd17: t = '{5'd20, OP_PY,  OP_PY,  1'b0, SH_32};
			5'd18: t = '{5'd21, OP_RX,  OP_ONE, 1'b0, SH_16};
			5'd19: t = '{5'd22, OP_RY,  OP_ONE, 1'b0, SH_16};
			5'd20: t = '{5'd23, OP_RZ,  OP_ONE, 1'b0, SH_16};
			5'd21: t = '{5'd24, OP_PY,  OP_RZ,  1'b0, SH_32};
			5'd22: t = '{5'd24, OP_PZ,  OP_RY,  1'b1, SH_32};
			5'd23: t = '{5'd25, OP_PZ,  OP_RX,  1'b0, SH_32};
			5'd24: t = '{5'd25, OP_PX,  OP_RZ,  1'b1, SH_32};
			5'd25: t = '{5'd26, OP_PX,  OP_RY,  1'b0, SH_32};
			5'd26: t = '{5'd26, OP_PY,  OP_RX,  1'b1, SH_32};
			default: t = '{5'd0, OP_ONE, OP_ONE, 1'b0, SH_0};
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rine_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
`default_nettype none

module rine_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic [63:0]      prod_q
);

	// Register every product; the sequencer picks it up in the next cycle
	always_ff @(posedge clk) begin
		prod_q <= {32'b0, a} * {32'b0, b};
	end

endmodule

`default_nettype wire

// ===== rtl/core/rine_div.sv =====
// Restoring divider for the kernel ratio floor(k * 2^32 / den), 33 quotient bits,
// one bit per cycle. Uses rine_pkg for nothing; standalone.
`timescale 1ns / 1ps
`default_nettype none

module rine_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [50:0] den,
	output logic             done_q,
	output logic [32:0]      quo_q
);

	logic [50:0] rem_q;
	logic [50:0] den_q;
	logic [32:0] bits_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [51:0] trial;
	logic        ge;
	logic [51:0] diff;

	// One trial subtraction per cycle
	assign trial = {rem_q, bits_q[32]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'd33;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: quotient bits 32 down to 0; remainder starts at k >> 1
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {20'b0, num[31:1]};
			bits_q <= {num[0], 32'b0};
			den_q  <= den;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[50:0] : trial[50:0];
			bits_q <= {bits_q[31:0], 1'b0};
			quo_q  <= {quo_q[31:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/robust_icp_normal_equations.sv =====
// Per item: square the residual, run the divide, square the ratio into the weight, then multiply,
// weight and accumulate each of 27 terms; weight squaring is skipped when the weight is 1.0, the
// divide too when the divisor is zero. A final item then emits 27 sums, one per cycle while out_ready
// is high. No new item is taken before the last is done; all products use the one 32x32 multiplier.
// Reset: asynchronous, active low; clears all sums, sets kernel_scale to 1.0 (Q16.16).
// Depends on rine_pkg, rine_mul, rine_div.
`timescale 1ns / 1ps
`default_nettype none

module robust_icp_normal_equations (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rine_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rine_pkg::out_item_t     out_data,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_wdata
);
	import rine_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_SQ     = 12'b000000000010,
		S_DSTART = 12'b000000000100,
		S_DWAIT  = 12'b000000001000,
		S_WSQ    = 12'b000000010000,
		S_WCAP   = 12'b000000100000,
		S_TM     = 12'b000001000000,
		S_TL     = 12'b000010000000,
		S_TH     = 12'b000100000000,
		S_TA     = 12'b001000000000,
		S_TS     = 12'b010000000000,
		S_EMIT   = 12'b100000000000
	} state_t;

	state_t             st_q;
	logic [31:0]        kscale_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [32:0] rx_q, ry_q, rz_q;
	logic               final_q;
	logic [1:0]         cnt_q;
	logic [49:0]        rsq_q;
	logic [32:0]        w_q;
	logic [4:0]         step_q;
	logic [4:0]         emit_q;
	logic [63:0]        m_q;
	logic [63:0]        lo_q;
	logic [63:0]        term_q;
	logic [63:0]        sums_q [NUM_SUMS];
	out_item_t          out_q;
	logic               out_valid_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic        div_start, div_done;
	logic [32:0] div_quo;
	logic [50:0] den;
	term_t       cur;
	logic [31:0] mag_a, mag_b;
	logic        sgn_a, sgn_b;
	logic [95:0] wprod, shifted;
	logic [63:0] res;
	logic        cap;
	logic [64:0] acc;
	logic        emit_load;

	rine_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	rine_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (kscale_q),
		.den   (den),
		.done_q(div_done),
		.quo_q (div_quo)
	);

	function automatic logic [31:0] mag_of(input opsel_t s, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z,
			input logic signed [32:0] u, input logic signed [32:0] v,
			input logic signed [32:0] t);
		logic [32:0] r;
		case (s)
			OP_PX:   r = x[31] ? 33'(-{x[31], x}) : {1'b0, x};
			OP_PY:   r = y[31] ? 33'(-{y[31], y}) : {1'b0, y};
			OP_PZ:   r = z[31] ? 33'(-{z[31], z}) : {1'b0, z};
			OP_RX:   r = u[32] ? 33'(-u) : u;
			OP_RY:   r = v[32] ? 33'(-v) : v;
			OP_RZ:   r = t[32] ? 33'(-t) : t;
			default: r = 33'd1;
		endcase
		return r[31:0];
	endfunction

	function automatic logic sign_of(input opsel_t s, input logic [5:0] sg);
		logic r;
		case (s)
			OP_PX:   r = sg[0];
			OP_PY:   r = sg[1];
			OP_PZ:   r = sg[2];
			OP_RX:   r = sg[3];
			OP_RY:   r = sg[4];
			OP_RZ:   r = sg[5];
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Decode the current term and its operands
	assign cur   = term_of(step_q);
	assign mag_a = mag_of(cur.opa, px_q, py_q, pz_q, rx_q, ry_q, rz_q);
	assign mag_b = mag_of(cur.opb, px_q, py_q, pz_q, rx_q, ry_q, rz_q);
	assign sgn_a = sign_of(cur.opa, {rz_q[32], ry_q[32], rx_q[32], pz_q[31], py_q[31], px_q[31]});
	assign sgn_b = sign_of(cur.opb, {rz_q[32], ry_q[32], rx_q[32], pz_q[31], py_q[31], px_q[31]});

	assign den       = {19'b0, kscale_q} + {1'b0, rsq_q};
	assign div_start = (st_q == S_DSTART) && (den != '0);

	// Drive the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_SQ: begin
				case (cnt_q)
					2'd0:    mul_a = mag_of(OP_RX, px_q, py_q, pz_q, rx_q, ry_q, rz_q);
					2'd1:    mul_a = mag_of(OP_RY, px_q, py_q, pz_q, rx_q, ry_q, rz_q);
					default: mul_a = mag_of(OP_RZ, px_q, py_q, pz_q, rx_q, ry_q, rz_q);
				endcase
				mul_b = mul_a;
			end
			S_WSQ: begin
				mul_a = div_quo[31:0];
				mul_b = div_quo[31:0];
			end
			S_TM: begin
				mul_a = mag_a;
				mul_b = mag_b;
			end
			S_TL: begin
				mul_a = prod_q[31:0];
				mul_b = w_q[31:0];
			end
			S_TH: begin
				mul_a = m_q[63:32];
				mul_b = w_q[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Weight the product, drop fraction bits, cap the magnitude at 2^63
	always_comb begin
		wprod = w_q[32] ? {m_q, 32'b0} : ({32'b0, lo_q} + {prod_q, 32'b0});
		case (cur.sh)
			SH_16:   shifted = wprod >> 16;
			SH_32:   shifted = wprod >> 32;
			default: shifted = wprod;
		endcase
		cap = (shifted[95:64] != '0) || (shifted[63] && (shifted[62:0] != '0));
		res = cap ? 64'h8000_0000_0000_0000 : shifted[63:0];
	end

	// Saturating add into the target sum
	assign acc = {sums_q[cur.idx][63], sums_q[cur.idx]} + {term_q[63], term_q};

	assign emit_load = (st_q == S_EMIT) && (!out_valid_q || out_ready);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			kscale_q    <= 32'd65536;
			cnt_q       <= '0;
			step_q      <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SUMS; i++) begin
				sums_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				kscale_q <= cfg_wdata;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q  <= '0;
						step_q <= '0;
						st_q   <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						st_q <= S_DSTART;
					end
				end
				S_DSTART: begin
					st_q <= (den == '0) ? S_TM : S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						st_q <= div_quo[32] ? S_TM : S_WSQ;
					end
				end
				S_WSQ:  st_q <= S_WCAP;
				S_WCAP: st_q <= S_TM;
				S_TM:   st_q <= S_TL;
				S_TL:   st_q <= S_TH;
				S_TH:   st_q <= S_TA;
				S_TA:   st_q <= S_TS;
				S_TS: begin
					if (acc[64] != acc[63]) begin
						sums_q[cur.idx] <= acc[64] ? 64'h8000_0000_0000_0000
							: 64'h7FFF_FFFF_FFFF_FFFF;
					end else begin
						sums_q[cur.idx] <= acc[63:0];
					end
					if (step_q == LAST_TERM) begin
						emit_q <= '0;
						st_q   <= final_q ? S_EMIT : S_IDLE;
					end else begin
						step_q <= step_q + 5'd1;
						st_q   <= S_TM;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						emit_q <= emit_q + 5'd1;
						if (emit_q == LAST_ENTRY) begin
							for (int i = 0; i < NUM_SUMS; i++) begin
								sums_q[i] <= '0;
							end
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath: capture, squared residual, weight, term pipeline, output
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			px_q    <= in_data.src_x;
			py_q    <= in_data.src_y;
			pz_q    <= in_data.src_z;
			rx_q    <= 33'(in_data.src_x) - 33'(in_data.map_x);
			ry_q    <= 33'(in_data.src_y) - 33'(in_data.map_y);
			rz_q    <= 33'(in_data.src_z) - 33'(in_data.map_z);
			final_q <= in_data.final_pair;
			rsq_q   <= '0;
		end
		if (st_q == S_SQ && cnt_q != 2'd0) begin
			rsq_q <= rsq_q + {2'b0, prod_q[63:16]};
		end
		if (st_q == S_DSTART && den == '0) begin
			w_q <= '0;
		end
		if (st_q == S_DWAIT && div_done && div_quo[32]) begin
			w_q <= W_ONE;
		end
		if (st_q == S_WCAP) begin
			w_q <= {1'b0, prod_q[63:32]};
		end
		if (st_q == S_TL) begin
			m_q <= prod_q;
		end
		if (st_q == S_TH) begin
			lo_q <= prod_q;
		end
		if (st_q == S_TA) begin
			if (sgn_a ^ sgn_b ^ cur.neg) begin
				term_q <= 64'(-res);
			end else begin
				term_q <= res[63] ? 64'h7FFF_FFFF_FFFF_FFFF : res;
			end
		end
		if (emit_load) begin
			out_q.entry_index <= emit_q;
			out_q.entry_value <= sums_q[emit_q];
			out_q.run_last    <= (emit_q == LAST_ENTRY);
		end
	end

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/rine_chk.sv =====
// Port-level checker for robust_icp_normal_equations and its bind.
// Depends on rine_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rine_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire rine_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire rine_pkg::out_item_t out_data,
	input wire logic                cfg_we,
	input wire logic [31:0]         cfg_wdata
);
	import rine_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The last flag marks exactly the final entry
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.run_last == (out_data.entry_index == LAST_ENTRY)))
		else $error("run_last does not match entry index");

	// Entries stay in range
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_index <= LAST_ENTRY)
		else $error("entry index out of range");

	// An accepted item keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while item in progress");

endmodule

bind robust_icp_normal_equations rine_chk u_rine_chk (.*);

`default_nettype wire
